// ----- hdl/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants, codes and the index helper function of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

	localparam int ADDR_W  = 16;              // texel store address
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int TEXEL_W = 24;              // {blue, green, red}
	localparam int CHAN_W  = 8;
	localparam int SIZE_W  = 9;               // width / height register
	localparam int IDX_W   = 9;               // texel index after wrap or clamp
	localparam int FRAC_W  = 16;
	localparam int POS_W   = 44;              // scaled coordinate, Q.16
	localparam int INT_W   = POS_W - FRAC_W;  // integer part of a position
	localparam int LOC_W   = 26;              // in-tile position, Q.16
	localparam int LI_W    = LOC_W - FRAC_W;  // in-tile integer, -1 .. size
	localparam int COORD_W = 32;
	localparam int GAIN_W  = 16;
	localparam int OUT_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ROW_W   = 2 * IDX_W;
	localparam int WGT_W   = FRAC_W + 1;      // 65536 - frac
	localparam int TOP_W   = CHAN_W + FRAC_W + 1;
	localparam int LERP_W  = 40;              // Q8.32 blend, at most 255 * 2^32
	localparam int PROD_W  = LERP_W + GAIN_W + 1;
	localparam int QUOT_W  = PROD_W - 24;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BILINEAR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RGB      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd5;

	localparam logic signed [POS_W-1:0] HALF_TEXEL  = 44'sd32768;
	localparam logic signed [POS_W-1:0] ONE_Q16     = 44'sd65536;
	localparam logic [WGT_W-1:0]        ONE_WGT     = 17'd65536;
	localparam logic [PROD_W-1:0]       ROUND_BIAS  = 57'd255 << 23;
	localparam logic [QUOT_W-1:0]       SAT_LIMIT   = 33'd255 << 24;
	localparam logic [31:0]             RECIP_255   = 32'h8080_8081;
	localparam int                      RECIP_SHIFT = 39;
	localparam logic [OUT_W-1:0]        OUT_MAX     = 24'hFF_FFFF;

	// Wrap or clamp one texel index. i is the full floor index, li the index
	// within the current tile (-1 .. n), n the effective size.
	function automatic logic [IDX_W-1:0] fix_idx(input logic signed [INT_W-1:0] i,
			input logic signed [LI_W-1:0] li, input logic [SIZE_W-1:0] n,
			input logic clamp);
		logic signed [INT_W-1:0] nm1;
		logic [IDX_W-1:0] r;
		nm1 = $signed({{(INT_W-SIZE_W){1'b0}}, n}) - INT_W'(1);
		if (clamp) begin
			if (i < 0)
				r = '0;
			else if (i > nm1)
				r = n - IDX_W'(1);
			else
				r = i[IDX_W-1:0];
		end else begin
			if (li < 0)
				r = n - IDX_W'(1);
			else if (li >= $signed({1'b0, n}))
				r = '0;
			else
				r = li[IDX_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/bts_if.sv -----
// ----------------------------------------------------------------------------
// bts_if
// Channel interfaces of the texture sampler: command, result and register write.
// ----------------------------------------------------------------------------
interface bts_in_if;
	logic                                valid;
	logic                                ready;
	logic                                opcode;
	logic [bts_pkg::ADDR_W-1:0]          texel_addr;
	logic [bts_pkg::CHAN_W-1:0]          texel_red;
	logic [bts_pkg::CHAN_W-1:0]          texel_green;
	logic [bts_pkg::CHAN_W-1:0]          texel_blue;
	logic signed [bts_pkg::COORD_W-1:0]  u_coord;
	logic signed [bts_pkg::COORD_W-1:0]  v_coord;

	modport source (output valid, opcode, texel_addr, texel_red, texel_green, texel_blue,
		u_coord, v_coord, input ready);
	modport sink (input valid, opcode, texel_addr, texel_red, texel_green, texel_blue,
		u_coord, v_coord, output ready);
endinterface

interface bts_out_if;
	logic                        valid;
	logic                        ready;
	logic [bts_pkg::OUT_W-1:0]   red_out;
	logic [bts_pkg::OUT_W-1:0]   green_out;
	logic [bts_pkg::OUT_W-1:0]   blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface bts_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bts_pkg::CFG_IDX_W-1:0]     index;
	logic [bts_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/bilinear_texture_sampler_top.sv -----
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_top
// Texture unit with an on-chip texel store and nearest / bilinear filtering.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  - register writes (width, height, filter, edge mode, rgb, gain);
//          always ready, write only while the unit is idle.
//   cmd  - opcode 0 stores a texel at texel_addr, opcode 1 samples at u,v.
//   res  - one transfer per sample, Q8.16 colour, saturated.
// A bilinear sample makes four reads on the single texel RAM read port
//   (one per neighbour); a nearest sample or a texel write makes one access.
//   A sample passes the command register, stages 2 and 3, the read sequencer,
//   the read pending and collection registers, stages 6 to 8 and the result register.
// The texel store is a 64K x 24 RAM with no reset; sampling a texel that
//   was never written gives an unspecified colour. Reset restores the
//   register defaults and empties the pipeline.
// When res is stalled the whole pipeline holds, including the RAM read
//   sequencer; cmd.ready drops until the result register drains.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_top #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	bts_cfg_if.sink   cfg,
	bts_in_if.sink    cmd,
	bts_out_if.source res
);
	import bts_pkg::*;

	// configuration
	logic [SIZE_W-1:0] width_q, height_q;
	logic              bil_q, clamp_q, rgb_q;
	logic [GAIN_W-1:0] gain_q;
	logic [SIZE_W-1:0] wz, hz;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(1);
			height_q <= SIZE_W'(1);
			bil_q    <= 1'b1;
			clamp_q  <= 1'b0;
			rgb_q    <= 1'b1;
			gain_q   <= GAIN_W'(256);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WIDTH:    width_q  <= cfg.data[SIZE_W-1:0];
				REG_HEIGHT:   height_q <= cfg.data[SIZE_W-1:0];
				REG_BILINEAR: bil_q    <= cfg.data[0];
				REG_CLAMP:    clamp_q  <= cfg.data[0];
				REG_RGB:      rgb_q    <= cfg.data[0];
				REG_GAIN:     gain_q   <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			wz = SIZE_W'(1);
		else if (32'(width_q) > MAX_WIDTH)
			wz = SIZE_W'(MAX_WIDTH);
		else
			wz = width_q;
		if (height_q == '0)
			hz = SIZE_W'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			hz = SIZE_W'(MAX_HEIGHT);
		else
			hz = height_q;
	end

	// flow control
	logic en, up_adv;
	logic seq_v_q, seq_op_q, seq_last;
	logic [1:0] seq_cnt_q;
	logic res_v_q;

	assign en       = !res_v_q || res.ready;
	assign seq_last = (seq_op_q == OP_WRITE) || !bil_q || (seq_cnt_q == 2'd3);
	assign up_adv   = en && (!seq_v_q || seq_last);
	assign cmd.ready = up_adv;

	// stage 1: command register
	logic                      s1_v, s1_op;
	logic [ADDR_W-1:0]         s1_addr;
	logic [TEXEL_W-1:0]        s1_data;
	logic signed [COORD_W-1:0] s1_u, s1_v_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v <= 1'b0;
		else if (up_adv)
			s1_v <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (up_adv) begin
			s1_op   <= cmd.opcode;
			s1_addr <= cmd.texel_addr;
			s1_data <= {cmd.texel_blue, cmd.texel_green, cmd.texel_red};
			s1_u    <= cmd.u_coord;
			s1_v_c  <= cmd.v_coord;
		end
	end

	// scale, offset and split into integer and fraction
	logic signed [POS_W-1:0] off, pu, qv, pv;
	logic [LOC_W-1:0]        lu_raw, lv_raw;
	logic signed [LOC_W-1:0] lu, lv;

	always_comb begin
		off    = bil_q ? HALF_TEXEL : '0;
		pu     = POS_W'(s1_u) * $signed({{(POS_W-SIZE_W){1'b0}}, wz}) - off;
		qv     = ONE_Q16 - POS_W'(s1_v_c);
		pv     = qv * $signed({{(POS_W-SIZE_W){1'b0}}, hz}) - off;
		// position within the current repeat of the texture
		lu_raw = LOC_W'(s1_u[FRAC_W-1:0]) * LOC_W'(wz);
		lv_raw = LOC_W'(qv[FRAC_W-1:0]) * LOC_W'(hz);
		lu     = $signed(lu_raw) - off[LOC_W-1:0];
		lv     = $signed(lv_raw) - off[LOC_W-1:0];
	end

	// stage 2
	logic                    s2_v, s2_op;
	logic [ADDR_W-1:0]       s2_addr;
	logic [TEXEL_W-1:0]      s2_data;
	logic signed [INT_W-1:0] s2_iu, s2_iv;
	logic signed [LI_W-1:0]  s2_liu, s2_liv;
	logic [FRAC_W-1:0]       s2_fu, s2_fv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_v <= 1'b0;
		else if (up_adv)
			s2_v <= s1_v;
	end

	always_ff @(posedge clk) begin
		if (up_adv) begin
			s2_op   <= s1_op;
			s2_addr <= s1_addr;
			s2_data <= s1_data;
			s2_iu   <= pu[POS_W-1:FRAC_W];
			s2_iv   <= pv[POS_W-1:FRAC_W];
			s2_liu  <= lu[LOC_W-1:FRAC_W];
			s2_liv  <= lv[LOC_W-1:FRAC_W];
			s2_fu   <= bil_q ? pu[FRAC_W-1:0] : '0;
			s2_fv   <= bil_q ? pv[FRAC_W-1:0] : '0;
		end
	end

	// stage 3: wrapped / clamped neighbour indices
	logic                 s3_v, s3_op;
	logic [ADDR_W-1:0]    s3_addr;
	logic [TEXEL_W-1:0]   s3_data;
	logic [IDX_W-1:0]     s3_x0, s3_x1, s3_y0, s3_y1;
	logic [FRAC_W-1:0]    s3_fu, s3_fv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s3_v <= 1'b0;
		else if (up_adv)
			s3_v <= s2_v;
	end

	always_ff @(posedge clk) begin
		if (up_adv) begin
			s3_op   <= s2_op;
			s3_addr <= s2_addr;
			s3_data <= s2_data;
			s3_x0   <= fix_idx(s2_iu, s2_liu, wz, clamp_q);
			s3_x1   <= fix_idx(s2_iu + INT_W'(1), s2_liu + LI_W'(1), wz, clamp_q);
			s3_y0   <= fix_idx(s2_iv, s2_liv, hz, clamp_q);
			s3_y1   <= fix_idx(s2_iv + INT_W'(1), s2_liv + LI_W'(1), hz, clamp_q);
			s3_fu   <= s2_fu;
			s3_fv   <= s2_fv;
		end
	end

	// row bases and texel addresses
	logic [ROW_W-1:0] row0, row1;

	assign row0 = ROW_W'(s3_y0) * ROW_W'(wz);
	assign row1 = ROW_W'(s3_y1) * ROW_W'(wz);

	// read sequencer: one RAM access per cycle while the result side is not stalled
	logic [ADDR_W-1:0]  seq_addr_q [4];
	logic [TEXEL_W-1:0] seq_data_q;
	logic [FRAC_W-1:0]  seq_fu_q, seq_fv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_v_q   <= 1'b0;
			seq_cnt_q <= '0;
		end else if (up_adv) begin
			seq_v_q   <= s3_v;
			seq_cnt_q <= '0;
		end else if (en && seq_v_q) begin
			seq_cnt_q <= seq_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (up_adv) begin
			seq_op_q      <= s3_op;
			seq_data_q    <= s3_data;
			seq_fu_q      <= s3_fu;
			seq_fv_q      <= s3_fv;
			seq_addr_q[0] <= (s3_op == OP_WRITE) ? s3_addr
				: row0[ADDR_W-1:0] + ADDR_W'(s3_x0);
			seq_addr_q[1] <= row0[ADDR_W-1:0] + ADDR_W'(s3_x1);
			seq_addr_q[2] <= row1[ADDR_W-1:0] + ADDR_W'(s3_x0);
			seq_addr_q[3] <= row1[ADDR_W-1:0] + ADDR_W'(s3_x1);
		end
	end

	logic               wr_en, rd_en;
	logic [TEXEL_W-1:0] rd_data;

	assign wr_en = en && seq_v_q && (seq_op_q == OP_WRITE);
	assign rd_en = en && seq_v_q && (seq_op_q == OP_SAMPLE);

	bts_ram #(
		.WIDTH (TEXEL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (seq_addr_q[0]),
		.wr_data (seq_data_q),
		.rd_en   (rd_en),
		.rd_addr (seq_addr_q[seq_cnt_q]),
		.rd_data (rd_data)
	);

	// read pending, then texel collection
	logic              pend_v, pend_last;
	logic [1:0]        pend_k;
	logic [FRAC_W-1:0] pend_fu, pend_fv;
	logic [TEXEL_W-1:0] tex_q [4];
	logic              s5_v;
	logic [FRAC_W-1:0] s5_fu, s5_fv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v <= 1'b0;
			s5_v   <= 1'b0;
		end else if (en) begin
			pend_v <= rd_en;
			s5_v   <= pend_v && pend_last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pend_k    <= seq_cnt_q;
			pend_last <= seq_last;
			pend_fu   <= seq_fu_q;
			pend_fv   <= seq_fv_q;
			s5_fu     <= pend_fu;
			s5_fv     <= pend_fv;
			if (pend_v)
				tex_q[pend_k] <= rd_data;
		end
	end

	// stage 6: horizontal blend per channel
	logic [TOP_W-1:0]  top_c [3], bot_c [3];
	logic [TOP_W-1:0]  s6_top [3], s6_bot [3];
	logic [FRAC_W-1:0] s6_fv;
	logic              s6_v;

	always_comb begin
		logic [CHAN_W-1:0] c00, c01, c10, c11;
		logic [WGT_W-1:0]  wu0;
		wu0 = ONE_WGT - WGT_W'(s5_fu);
		for (int ch = 0; ch < 3; ch++) begin
			c00 = rgb_q ? tex_q[0][ch*CHAN_W +: CHAN_W] : tex_q[0][CHAN_W-1:0];
			// nearest mode reads only the first texel
			c01 = !bil_q ? c00 : rgb_q ? tex_q[1][ch*CHAN_W +: CHAN_W] : tex_q[1][CHAN_W-1:0];
			c10 = !bil_q ? c00 : rgb_q ? tex_q[2][ch*CHAN_W +: CHAN_W] : tex_q[2][CHAN_W-1:0];
			c11 = !bil_q ? c00 : rgb_q ? tex_q[3][ch*CHAN_W +: CHAN_W] : tex_q[3][CHAN_W-1:0];
			top_c[ch] = TOP_W'(c00) * TOP_W'(wu0) + TOP_W'(c01) * TOP_W'(s5_fu);
			bot_c[ch] = TOP_W'(c10) * TOP_W'(wu0) + TOP_W'(c11) * TOP_W'(s5_fu);
		end
	end

	// stage 7: vertical blend
	logic [LERP_W-1:0] lerp_c [3];
	logic [LERP_W-1:0] s7_l [3];
	logic              s7_v;

	always_comb begin
		logic [WGT_W-1:0] wv0;
		wv0 = ONE_WGT - WGT_W'(s6_fv);
		for (int ch = 0; ch < 3; ch++)
			lerp_c[ch] = LERP_W'(s6_top[ch]) * LERP_W'(wv0)
				+ LERP_W'(s6_bot[ch]) * LERP_W'(s6_fv);
	end

	// stage 8: gain and rounding, quotient by 2^24 taken here
	logic [PROD_W-1:0] prod_c [3];
	logic [31:0]       s8_y [3];
	logic [2:0]        s8_sat;
	logic              s8_v;

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			prod_c[ch] = PROD_W'(s7_l[ch]) * PROD_W'(gain_q) + ROUND_BIAS;
	end

	// output: divide by 255 through the reciprocal, saturate
	logic [OUT_W-1:0] res_q [3];
	logic [63:0]      quot_c [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			quot_c[ch] = (64'(s8_y[ch]) * 64'(RECIP_255)) >> RECIP_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s6_v    <= 1'b0;
			s7_v    <= 1'b0;
			s8_v    <= 1'b0;
			res_v_q <= 1'b0;
		end else if (en) begin
			s6_v    <= s5_v;
			s7_v    <= s6_v;
			s8_v    <= s7_v;
			res_v_q <= s8_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s6_fv <= s5_fv;
			for (int ch = 0; ch < 3; ch++) begin
				s6_top[ch] <= top_c[ch];
				s6_bot[ch] <= bot_c[ch];
				s7_l[ch]   <= lerp_c[ch];
				s8_y[ch]   <= prod_c[ch][55:24];
				s8_sat[ch] <= prod_c[ch][PROD_W-1:24] >= SAT_LIMIT;
				res_q[ch]  <= s8_sat[ch] ? OUT_MAX : quot_c[ch][OUT_W-1:0];
			end
		end
	end

	assign res.valid     = res_v_q;
	assign res.red_out   = res_q[0];
	assign res.green_out = res_q[1];
	assign res.blue_out  = res_q[2];

endmodule

// ----- hdl/bts_ram.sv -----
// ----------------------------------------------------------------------------
// bts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bilinear texture sampler: texel writes and
// nearest / bilinear samples under many register settings. Each result is
// checked in order against a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import bts_pkg::*;

	localparam int WDOG_LIMIT = 5000;
	localparam int IDLE_WAIT  = 30;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
	} colour_t;

	logic clk;
	logic arst_n;
	bts_cfg_if cfg_if();
	bts_in_if  cmd_if();
	bts_out_if res_if();

	bilinear_texture_sampler_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_if.sink),
		.cmd   (cmd_if.sink),
		.res   (res_if.source)
	);

	// bench copy of the registers and of the texel store
	logic [SIZE_W-1:0]  r_width, r_height;
	logic               r_bilinear, r_clamp, r_rgb;
	logic [GAIN_W-1:0]  r_gain;
	logic [TEXEL_W-1:0] texels [DEPTH];
	bit                 texel_valid [DEPTH];

	colour_t colour_q[$];
	int      fails;
	bit      no_idle;
	int      quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// --- predictor ---------------------------------------------------------
	function automatic longint eff_size(input logic [SIZE_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > 256)
			return 256;
		return longint'(r);
	endfunction

	function automatic longint fix_index(input longint i, input longint n);
		if (r_clamp) begin
			if (i < 0)
				return 0;
			if (i > n - 1)
				return n - 1;
			return i;
		end
		i = i % n;
		if (i < 0)
			i += n;
		return i;
	endfunction

	// texel addresses of the four neighbours and the blend weights
	task automatic locate(input logic signed [31:0] u, input logic signed [31:0] v,
			output logic [ADDR_W-1:0] addr [4], output longint fu, output longint fv);
		longint w, h, pu, pv, iu, iv, iu0, iu1, iv0, iv1;
		w  = eff_size(r_width);
		h  = eff_size(r_height);
		pu = longint'(u) * w;
		pv = (65536 - longint'(v)) * h;
		if (r_bilinear) begin
			pu -= 32768;
			pv -= 32768;
		end
		iu  = pu >>> 16;
		iv  = pv >>> 16;
		fu  = pu & 64'hFFFF;
		fv  = pv & 64'hFFFF;
		iu0 = fix_index(iu, w);
		iu1 = fix_index(iu + 1, w);
		iv0 = fix_index(iv, h);
		iv1 = fix_index(iv + 1, h);
		addr[0] = ADDR_W'(iu0 + iv0 * w);
		addr[1] = ADDR_W'(iu1 + iv0 * w);
		addr[2] = ADDR_W'(iu0 + iv1 * w);
		addr[3] = ADDR_W'(iu1 + iv1 * w);
	endtask

	task automatic predict_sample(input logic signed [31:0] u,
			input logic signed [31:0] v, output colour_t c);
		logic [ADDR_W-1:0] addr [4];
		longint fu, fv;
		longint unsigned c00, c01, c10, c11, top, bot, l, q;
		logic [OUT_W-1:0] chan [3];
		int sh;
		locate(u, v, addr, fu, fv);
		for (int ch = 0; ch < 3; ch++) begin
			sh  = r_rgb ? 8 * ch : 0;
			c00 = (texels[addr[0]] >> sh) & 8'hFF;
			if (r_bilinear) begin
				c01 = (texels[addr[1]] >> sh) & 8'hFF;
				c10 = (texels[addr[2]] >> sh) & 8'hFF;
				c11 = (texels[addr[3]] >> sh) & 8'hFF;
				top = c00 * (65536 - fu) + c01 * fu;
				bot = c10 * (65536 - fu) + c11 * fu;
				l   = top * (65536 - fv) + bot * fv;
			end else begin
				l = c00 << 32;
			end
			q = (l * r_gain + (64'd255 << 23)) / (64'd255 << 24);
			chan[ch] = (q > 64'hFFFFFF) ? OUT_MAX : q[OUT_W-1:0];
		end
		c = '{red: chan[0], green: chan[1], blue: chan[2]};
	endtask

	// --- drivers -------------------------------------------------------------
	// Called on a falling edge; returns on the falling edge after the transfer.
	task automatic send_cmd(input logic op, input logic [ADDR_W-1:0] addr,
			input logic [TEXEL_W-1:0] rgb, input logic signed [31:0] u,
			input logic signed [31:0] v);
		int gap;
		colour_t c;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			cmd_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.opcode      = op;
		cmd_if.texel_addr  = addr;
		cmd_if.texel_red   = rgb[7:0];
		cmd_if.texel_green = rgb[15:8];
		cmd_if.texel_blue  = rgb[23:16];
		cmd_if.u_coord     = u;
		cmd_if.v_coord     = v;
		cmd_if.valid       = 1'b1;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		if (op == OP_WRITE) begin
			texels[addr]      = rgb;
			texel_valid[addr] = 1'b1;
		end else begin
			predict_sample(u, v, c);
			colour_q.push_back(c);
		end
		@(negedge clk);
	endtask

	task automatic write_texel(input logic [ADDR_W-1:0] addr, input logic [TEXEL_W-1:0] rgb);
		send_cmd(OP_WRITE, addr, rgb, $urandom, $urandom);
	endtask

	// fill any neighbour never written first, so no undefined texel is read
	task automatic sample_at(input logic signed [31:0] u, input logic signed [31:0] v);
		logic [ADDR_W-1:0] addr [4];
		longint fu, fv;
		locate(u, v, addr, fu, fv);
		for (int k = 0; k < 4; k++)
			if (!texel_valid[addr[k]] && (k == 0 || r_bilinear))
				write_texel(addr[k], $urandom);
		send_cmd(OP_SAMPLE, $urandom, $urandom, u, v);
	endtask

	task automatic drain();
		cmd_if.valid = 1'b0;
		while (colour_q.size() != 0)
			@(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.index = idx;
		cfg_if.data  = data;
		cfg_if.valid = 1'b1;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_WIDTH:    r_width    = data[SIZE_W-1:0];
			REG_HEIGHT:   r_height   = data[SIZE_W-1:0];
			REG_BILINEAR: r_bilinear = data[0];
			REG_CLAMP:    r_clamp    = data[0];
			REG_RGB:      r_rgb      = data[0];
			REG_GAIN:     r_gain     = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_mode(input int w, input int h, input bit bil, input bit clmp,
			input bit rgb, input int g);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_BILINEAR, bil);
		write_reg(REG_CLAMP, clmp);
		write_reg(REG_RGB, rgb);
		write_reg(REG_GAIN, g);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return $signed(32'h8000_0000) + $urandom_range(0, 3);
			2:       return 32'sh7FFF_FFFF - $urandom_range(0, 3);
			3:       return 32'(65536 * $urandom_range(0, 2));
			default: return $signed(32'($urandom_range(0, 6 * 65536))) - 3 * 65536;
		endcase
	endfunction

	// --- result side ---------------------------------------------------------
	initial begin
		int stall;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				res_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready = 1'b1;
			@(posedge clk);
			while (!res_if.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		colour_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (colour_q.size() == 0) begin
				$display("%0t: result transfer with nothing expected, got %h %h %h", $realtime,
					res_if.red_out, res_if.green_out, res_if.blue_out);
				fails++;
			end else begin
				e = colour_q.pop_front();
				if (res_if.red_out !== e.red) begin
					$display("%0t: red exp %h got %h", $realtime, e.red, res_if.red_out);
					fails++;
				end
				if (res_if.green_out !== e.green) begin
					$display("%0t: green exp %h got %h", $realtime, e.green, res_if.green_out);
					fails++;
				end
				if (res_if.blue_out !== e.blue) begin
					$display("%0t: blue exp %h got %h", $realtime, e.blue, res_if.blue_out);
					fails++;
				end
			end
		end
	end

	// watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// --- tests ---------------------------------------------------------------
	task automatic test_reset_values();
		// 1x1 texture, bilinear, wrap, rgb, unity gain
		write_texel(0, 24'hFF_80_01);
		sample_at(0, 0);
		sample_at(32'sh0000_8000, 32'sh0000_8000);
	endtask

	task automatic test_directed();
		set_mode(4, 3, 1, 0, 1, 256);
		for (int a = 0; a < 12; a++)
			write_texel(a, (a == 0) ? 24'h000000 : (a == 11) ? 24'hFFFFFF : $urandom);
		write_texel(16'hFFFF, 24'hFFFFFF);
		sample_at(32'sh8000_0000, 32'sh7FFF_FFFF);
		sample_at(32'sh7FFF_FFFF, 32'sh8000_0000);
		sample_at(-1, 65537);
		sample_at(65536, 0);
		drain();
		write_reg(REG_CLAMP, 1);
		sample_at(32'sh8000_0000, 32'sh8000_0000);
		sample_at(-32768, 32'sh0001_8000);
		sample_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		set_mode(4, 3, 0, 1, 0, 16'hFFFF);
		sample_at(32'sh0000_C000, 32'sh0000_4000);
		set_mode(4, 3, 0, 0, 1, 0);
		sample_at(32'sh0000_C000, -5);
	endtask

	task automatic test_random_phase(input int w, input int h, input bit bil,
			input bit clmp, input bit rgb, input int g, input int n);
		int span;
		set_mode(w, h, bil, clmp, rgb, g);
		if ($urandom_range(0, 7) == 0)
			write_reg($urandom_range(6, 7), $urandom);
		no_idle = ($urandom_range(0, 3) == 0);
		span = int'(eff_size(w) * eff_size(h));
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0:       write_texel($urandom_range(0, span - 1), $urandom);
				1:       write_texel($urandom, $urandom);
				default: sample_at(rand_coord(), rand_coord());
			endcase
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int g;
		arst_n = 1'b0;
		fails = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		r_width = 1; r_height = 1; r_bilinear = 1; r_clamp = 0; r_rgb = 1; r_gain = 256;
		cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
		cmd_if.valid = 1'b0; cmd_if.opcode = OP_WRITE; cmd_if.texel_addr = '0;
		cmd_if.texel_red = '0; cmd_if.texel_green = '0; cmd_if.texel_blue = '0;
		cmd_if.u_coord = '0; cmd_if.v_coord = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_directed();
		test_random_phase(1, 1, 1, 0, 1, 256, 100);
		test_random_phase(256, 256, 1, 1, 1, 65535, 120);
		test_random_phase(0, 511, 0, 0, 0, 0, 100);
		test_random_phase(511, 0, 1, 0, 1, 128, 100);
		test_random_phase(257, 3, 0, 1, 1, 512, 100);
		for (int p = 0; p < 9; p++) begin
			g = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1024);
			test_random_phase($urandom_range(1, 16), $urandom_range(1, 16),
				$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), g, 130);
		end

		drain();
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
